// ===== hdl/lmpf_pkg.sv =====
// Package for the 3x3 local-maximum peak finder.
// Holds register indexes, record kinds, queue sizing and the entry flag type.
// No dependencies.
`default_nettype none

package lmpf_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_FRAME_WIDTH      = 3'd0,
        REG_FRAME_HEIGHT     = 3'd1,
        REG_PEAK_THRESHOLD   = 3'd2,
        REG_STABILITY_MARGIN = 3'd3,
        REG_SUBPIXEL_ENABLE  = 3'd4
    } reg_index_t;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int WIDTH_BITS     = 13;
    localparam int HEIGHT_BITS    = 16;
    localparam int COUNT_BITS     = 24;
    localparam int COLUMN_Q_BITS  = 20;
    localparam int ROW_Q_BITS     = 24;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic KIND_PEAK    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 13'd4096;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd3;
    localparam logic [COUNT_BITS-1:0]  COUNT_MAX    = 24'hFFFFFF;

    // What a queued pixel asks of the back end.
    typedef struct packed {
        logic is_peak;
        logic is_end;
        logic sub_en;
    } entry_flags_t;

endpackage

`default_nettype wire

// ===== hdl/lmpf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module lmpf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lmpf_fifo.sv =====
// Short register queue between the front end and the back end.
// Depends on nothing; width and depth come from the instantiating module.
`default_nettype none

module lmpf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire logic [WIDTH-1:0]           push_data,
    input  wire logic                       pop,
    output logic      [WIDTH-1:0]           pop_data,
    output logic                            empty,
    output logic      [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slots [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        if (p == PW'(DEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = slots[rd_ptr_reg];
    assign empty    = (count_reg == '0);
    assign count    = count_reg;

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != CW'(DEPTH)) || pop)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

// ===== hdl/lmpf_front.sv =====
// Front end: raster counters, line stores, 3x3 window and peak classification.
// Uses lmpf_pkg and lmpf_ram; pushes one entry per pixel that causes results.
`default_nettype none

module lmpf_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int PIXEL_BITS = 16,
    parameter int QDEPTH     = 4,
    parameter int EW         = 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 pixel_valid,
    output logic                                      pixel_ready,
    input  wire logic [PIXEL_BITS-1:0]                pixel_value,
    input  wire logic [lmpf_pkg::WIDTH_BITS-1:0]      frame_width,
    input  wire logic [lmpf_pkg::HEIGHT_BITS-1:0]     frame_height,
    input  wire logic [lmpf_pkg::CFG_DATA_BITS-1:0]   peak_threshold,
    input  wire logic [lmpf_pkg::CFG_DATA_BITS-1:0]   stability_margin,
    input  wire logic                                 subpixel_enable,
    input  wire logic [$clog2(QDEPTH+1)-1:0]          queue_count,
    output logic                                      push,
    output logic      [EW-1:0]                        push_data
);
    import lmpf_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = ($clog2(MAX_WIDTH + 1) > WIDTH_BITS) ?
                         $clog2(MAX_WIDTH + 1) : WIDTH_BITS;
    localparam int MW  = ((PIXEL_BITS > CFG_DATA_BITS) ? PIXEL_BITS : CFG_DATA_BITS) + 1;
    localparam int SB  = PIXEL_BITS + 4;
    localparam int DB  = PIXEL_BITS + 3;
    localparam int QCW = $clog2(QDEPTH + 1);

    logic [CW-1:0]          col_reg, col_next;
    logic [HEIGHT_BITS-1:0] row_reg, row_next;
    logic [COUNT_BITS-1:0]  cnt_reg, cnt_next;

    logic                   s1_valid_reg;
    logic [PIXEL_BITS-1:0]  s1_pix_reg;
    logic [CW-1:0]          s1_col_reg;
    logic [HEIGHT_BITS-1:0] s1_row_reg;
    logic                   s1_inner_reg;
    logic                   s1_end_reg;

    logic [PIXEL_BITS-1:0]  win_reg [9];
    logic [PIXEL_BITS-1:0]  win_next [9];
    logic [PIXEL_BITS-1:0]  top_rd, mid_rd;

    logic                   accept;
    logic [WW-1:0]          w_eff, w_last;
    logic [HEIGHT_BITS-1:0] h_eff, h_last;
    logic                   row_end, frame_end, inner;

    logic [MW-1:0]          ctr_x, thr_x, mar_x;
    logic                   is_peak;
    logic [SB-1:0]          sum;
    logic [PIXEL_BITS+1:0]  left3, right3, top3, bot3;
    logic signed [DB-1:0]   dx, dy;
    logic [COUNT_BITS-1:0]  cnt_inc;
    entry_flags_t           flags;

    assign accept      = pixel_valid && pixel_ready;
    assign pixel_ready = ({1'b0, queue_count} + (QCW+1)'(s1_valid_reg)) < (QCW+1)'(QDEPTH);

    // Effective frame size with the out-of-range values folded in.
    always_comb
    begin
        if (frame_width < WIDTH_BITS'(3))
        begin
            w_eff = WW'(3);
        end
        else if (WW'(frame_width) > WW'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(frame_width);
        end
        h_eff     = (frame_height < HEIGHT_BITS'(3)) ? HEIGHT_BITS'(3) : frame_height;
        w_last    = w_eff - 1'b1;
        h_last    = h_eff - 1'b1;
        row_end   = WW'(col_reg) >= w_last;
        frame_end = row_end && (row_reg >= h_last);
        inner     = (row_reg >= HEIGHT_BITS'(2)) && (col_reg >= CW'(2)) &&
                    (WW'(col_reg) <= w_last) && (row_reg <= h_last);
        col_next  = row_end ? '0 : col_reg + 1'b1;
        if (!row_end)
        begin
            row_next = row_reg;
        end
        else if (frame_end)
        begin
            row_next = '0;
        end
        else
        begin
            row_next = row_reg + 1'b1;
        end
    end

    lmpf_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_older (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (mid_rd),
        .re    (accept),
        .raddr (col_reg),
        .rdata (top_rd)
    );

    lmpf_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_newer (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (s1_pix_reg),
        .re    (accept),
        .raddr (col_reg),
        .rdata (mid_rd)
    );

    // Window index is row*3+col, row 0 oldest, column 2 newest.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i*3]   = win_reg[i*3+1];
            win_next[i*3+1] = win_reg[i*3+2];
        end
        win_next[2] = top_rd;
        win_next[5] = mid_rd;
        win_next[8] = s1_pix_reg;
    end

    always_comb
    begin
        ctr_x   = MW'(win_next[4]);
        thr_x   = MW'(peak_threshold);
        mar_x   = MW'(stability_margin);
        is_peak = s1_inner_reg && (ctr_x > thr_x);
        for (int k = 0; k < 9; k++)
        begin
            if (k != 4 && !((MW'(win_next[k]) + mar_x) < ctr_x))
            begin
                is_peak = 1'b0;
            end
        end
        sum = '0;
        for (int k = 0; k < 9; k++)
        begin
            sum = sum + SB'(win_next[k]);
        end
        left3  = (PIXEL_BITS+2)'(win_next[0]) + (PIXEL_BITS+2)'(win_next[3]) +
                 (PIXEL_BITS+2)'(win_next[6]);
        right3 = (PIXEL_BITS+2)'(win_next[2]) + (PIXEL_BITS+2)'(win_next[5]) +
                 (PIXEL_BITS+2)'(win_next[8]);
        top3   = (PIXEL_BITS+2)'(win_next[0]) + (PIXEL_BITS+2)'(win_next[1]) +
                 (PIXEL_BITS+2)'(win_next[2]);
        bot3   = (PIXEL_BITS+2)'(win_next[6]) + (PIXEL_BITS+2)'(win_next[7]) +
                 (PIXEL_BITS+2)'(win_next[8]);
        dx     = $signed({1'b0, right3}) - $signed({1'b0, left3});
        dy     = $signed({1'b0, bot3}) - $signed({1'b0, top3});
        cnt_inc = (is_peak && cnt_reg != COUNT_MAX) ? cnt_reg + 1'b1 : cnt_reg;
        cnt_next = s1_end_reg ? '0 : cnt_inc;
        flags.is_peak = is_peak;
        flags.is_end  = s1_end_reg;
        flags.sub_en  = subpixel_enable;
    end

    assign push      = s1_valid_reg && (is_peak || s1_end_reg);
    assign push_data = {flags, s1_col_reg - 1'b1, s1_row_reg - 1'b1, cnt_inc,
                        dx, dy, sum};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            cnt_reg      <= '0;
            s1_valid_reg <= 1'b0;
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (s1_valid_reg)
            begin
                cnt_reg <= cnt_next;
                for (int k = 0; k < 9; k++)
                begin
                    win_reg[k] <= win_next[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg   <= pixel_value;
            s1_col_reg   <= col_reg;
            s1_row_reg   <= row_reg;
            s1_inner_reg <= inner;
            s1_end_reg   <= frame_end;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lmpf_back.sv =====
// Back end: centre-of-gravity division and result formatting.
// Uses lmpf_pkg; pops entries from the queue and drives the result channel.
`default_nettype none

module lmpf_back #(
    parameter int MAX_WIDTH  = 4096,
    parameter int PIXEL_BITS = 16,
    parameter int FRAC_BITS  = 8,
    parameter int EW         = 8
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  queue_empty,
    input  wire logic [EW-1:0]                         pop_data,
    output logic                                       pop,
    output logic                                       result_valid,
    input  wire logic                                  result_ready,
    output logic                                       record_kind,
    output logic      [lmpf_pkg::COLUMN_Q_BITS-1:0]    column_q8,
    output logic      [lmpf_pkg::ROW_Q_BITS-1:0]       row_q8,
    output logic      [lmpf_pkg::COUNT_BITS-1:0]       peak_total,
    output logic                                       last_of_run
);
    import lmpf_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int SB  = PIXEL_BITS + 4;
    localparam int DB  = PIXEL_BITS + 3;
    localparam int MB  = PIXEL_BITS + 2;
    localparam int NB  = MB + FRAC_BITS;
    localparam int NCW = $clog2(NB + 1);
    localparam int T0  = (CW > HEIGHT_BITS) ? CW : HEIGHT_BITS;
    localparam int T1  = ((T0 + FRAC_BITS > NB) ? T0 + FRAC_BITS : NB);
    localparam int TW  = ((T1 > ROW_Q_BITS) ? T1 : ROW_Q_BITS) + 2;

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_FIX, S_PEAK, S_END} state_t;

    state_t                 state_reg;
    entry_flags_t           e_flags;
    logic [CW-1:0]          e_col;
    logic [HEIGHT_BITS-1:0] e_row;
    logic [COUNT_BITS-1:0]  e_total;
    logic signed [DB-1:0]   e_dx, e_dy;
    logic [SB-1:0]          e_sum;

    logic                   is_end_reg;
    logic [CW-1:0]          col_reg;
    logic [HEIGHT_BITS-1:0] row_reg;
    logic [COUNT_BITS-1:0]  total_reg;
    logic [SB-1:0]          den_reg;
    logic                   negx_reg, negy_reg;
    logic [NB-1:0]          numx_reg, numy_reg, qx_reg, qy_reg;
    logic [SB:0]            remx_reg, remy_reg;
    logic [NCW-1:0]         div_cnt_reg;

    logic                   out_valid_reg, kind_reg, last_reg;
    logic [COLUMN_Q_BITS-1:0] colq_reg;
    logic [ROW_Q_BITS-1:0]  rowq_reg;
    logic [COUNT_BITS-1:0]  outtot_reg;

    logic [SB:0]            remx_sh, remy_sh;
    logic                   fitx, fity;
    logic signed [TW-1:0]   qx_s, qy_s, colq_s, rowq_s;
    logic [MB-1:0]          magx, magy;
    logic                   out_take;

    assign {e_flags, e_col, e_row, e_total, e_dx, e_dy, e_sum} = pop_data;
    assign pop      = (state_reg == S_IDLE) && !queue_empty;
    assign out_take = out_valid_reg && result_ready;

    always_comb
    begin
        magx    = MB'(e_dx[DB-1] ? -e_dx : e_dx);
        magy    = MB'(e_dy[DB-1] ? -e_dy : e_dy);
        // One restoring division step for each axis.
        remx_sh = {remx_reg[SB-1:0], numx_reg[NB-1]};
        remy_sh = {remy_reg[SB-1:0], numy_reg[NB-1]};
        fitx    = remx_sh >= {1'b0, den_reg};
        fity    = remy_sh >= {1'b0, den_reg};
        qx_s    = negx_reg ? -$signed(TW'(qx_reg)) : $signed(TW'(qx_reg));
        qy_s    = negy_reg ? -$signed(TW'(qy_reg)) : $signed(TW'(qy_reg));
        colq_s  = $signed(TW'({col_reg, FRAC_BITS'(0)})) + qx_s;
        rowq_s  = $signed(TW'({row_reg, FRAC_BITS'(0)})) + qy_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!queue_empty)
                    begin
                        is_end_reg <= e_flags.is_end;
                        col_reg    <= e_col;
                        row_reg    <= e_row;
                        total_reg  <= e_total;
                        den_reg    <= e_sum;
                        negx_reg   <= e_dx[DB-1];
                        negy_reg   <= e_dy[DB-1];
                        numx_reg   <= {magx, FRAC_BITS'(0)};
                        numy_reg   <= {magy, FRAC_BITS'(0)};
                        qx_reg     <= '0;
                        qy_reg     <= '0;
                        remx_reg   <= '0;
                        remy_reg   <= '0;
                        div_cnt_reg <= '0;
                        if (!e_flags.is_peak)
                        begin
                            kind_reg      <= KIND_SUMMARY;
                            colq_reg      <= '0;
                            rowq_reg      <= '0;
                            outtot_reg    <= e_total;
                            last_reg      <= 1'b1;
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_END;
                        end
                        else if (e_flags.sub_en && e_sum != '0)
                        begin
                            state_reg <= S_DIV;
                        end
                        else
                        begin
                            state_reg <= S_FIX;
                        end
                    end
                end
                S_DIV:
                begin
                    remx_reg    <= fitx ? remx_sh - {1'b0, den_reg} : remx_sh;
                    remy_reg    <= fity ? remy_sh - {1'b0, den_reg} : remy_sh;
                    qx_reg      <= {qx_reg[NB-2:0], fitx};
                    qy_reg      <= {qy_reg[NB-2:0], fity};
                    numx_reg    <= numx_reg << 1;
                    numy_reg    <= numy_reg << 1;
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == NCW'(NB - 1))
                    begin
                        state_reg <= S_FIX;
                    end
                end
                S_FIX:
                begin
                    kind_reg      <= KIND_PEAK;
                    colq_reg      <= colq_s[TW-1] ? '0 : COLUMN_Q_BITS'(colq_s);
                    rowq_reg      <= rowq_s[TW-1] ? '0 : ROW_Q_BITS'(rowq_s);
                    outtot_reg    <= total_reg;
                    last_reg      <= !is_end_reg;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_PEAK;
                end
                S_PEAK:
                begin
                    if (out_take)
                    begin
                        if (is_end_reg)
                        begin
                            kind_reg   <= KIND_SUMMARY;
                            colq_reg   <= '0;
                            rowq_reg   <= '0;
                            last_reg   <= 1'b1;
                            state_reg  <= S_END;
                        end
                        else
                        begin
                            out_valid_reg <= 1'b0;
                            state_reg     <= S_IDLE;
                        end
                    end
                end
                S_END:
                begin
                    if (out_take)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = out_valid_reg;
    assign record_kind  = kind_reg;
    assign column_q8    = colq_reg;
    assign row_q8       = rowq_reg;
    assign peak_total   = outtot_reg;
    assign last_of_run  = last_reg;

`ifndef ASSERT_OFF
    a_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg == ((state_reg == S_PEAK) || (state_reg == S_END)))
        else $error("result beat shown outside an output state");
    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_SUMMARY) |-> last_reg)
        else $error("summary beat not marked last");
`endif

endmodule

`default_nettype wire

// ===== hdl/local_max_peak_finder_3x3_unit.sv =====
// Top level of the 3x3 local-maximum peak finder with centroid offsets.
// Depends on lmpf_pkg, lmpf_front, lmpf_fifo, lmpf_back and lmpf_ram.
//
//  Channel   Signals                                   Direction
//  pixel     pixel_valid/pixel_ready, pixel_value      in
//  result    result_valid/result_ready, record_kind,   out
//            column_q8, row_q8, peak_total, last_of_run
//  config    cfg_we, cfg_index, cfg_data               in (write only)
//
// Pixels are taken one per cycle while the four-entry queue has room; the line
// store read is registered, so a pixel is classified in the cycle after it is taken.
// A queued peak leaves the queue in S_IDLE, passes through the serial divider (S_DIV) when
// offsets are on and the window sum is nonzero, is formatted in S_FIX and is presented in
// S_PEAK until taken; a summary leaves the queue and is presented in S_END until taken.
// Reset clears counters, window and control; the line stores need no clearing.
// A stalled result port backs up into the queue and then stalls pixel input.
`default_nettype none

module local_max_peak_finder_3x3_unit #(
    parameter int MAX_WIDTH  = 4096,
    parameter int PIXEL_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [lmpf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [lmpf_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  wire logic                                 pixel_valid,
    output logic                                      pixel_ready,
    input  wire logic [PIXEL_BITS-1:0]                pixel_value,
    output logic                                      result_valid,
    input  wire logic                                 result_ready,
    output logic                                      record_kind,
    output logic      [lmpf_pkg::COLUMN_Q_BITS-1:0]   column_q8,
    output logic      [lmpf_pkg::ROW_Q_BITS-1:0]      row_q8,
    output logic      [lmpf_pkg::COUNT_BITS-1:0]      peak_total,
    output logic                                      last_of_run
);
    import lmpf_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int EW  = 3 + CW + HEIGHT_BITS + COUNT_BITS +
                         2 * (PIXEL_BITS + 3) + (PIXEL_BITS + 4);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH_BITS-1:0]    frame_width_reg;
    logic [HEIGHT_BITS-1:0]   frame_height_reg;
    logic [CFG_DATA_BITS-1:0] peak_threshold_reg;
    logic [CFG_DATA_BITS-1:0] stability_margin_reg;
    logic                     subpixel_enable_reg;

    logic           push, pop, q_empty;
    logic [EW-1:0]  push_data, pop_data;
    logic [QCW-1:0] q_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg      <= WIDTH_RESET;
            frame_height_reg     <= HEIGHT_RESET;
            peak_threshold_reg   <= '0;
            stability_margin_reg <= '0;
            subpixel_enable_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:      frame_width_reg      <= cfg_data[WIDTH_BITS-1:0];
                REG_FRAME_HEIGHT:     frame_height_reg     <= cfg_data;
                REG_PEAK_THRESHOLD:   peak_threshold_reg   <= cfg_data;
                REG_STABILITY_MARGIN: stability_margin_reg <= cfg_data;
                REG_SUBPIXEL_ENABLE:  subpixel_enable_reg  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    lmpf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS),
        .QDEPTH     (QUEUE_DEPTH),
        .EW         (EW)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .pixel_valid      (pixel_valid),
        .pixel_ready      (pixel_ready),
        .pixel_value      (pixel_value),
        .frame_width      (frame_width_reg),
        .frame_height     (frame_height_reg),
        .peak_threshold   (peak_threshold_reg),
        .stability_margin (stability_margin_reg),
        .subpixel_enable  (subpixel_enable_reg),
        .queue_count      (q_count),
        .push             (push),
        .push_data        (push_data)
    );

    lmpf_fifo #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty),
        .count     (q_count)
    );

    lmpf_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .EW         (EW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (q_empty),
        .pop_data     (pop_data),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .record_kind  (record_kind),
        .column_q8    (column_q8),
        .row_q8       (row_q8),
        .peak_total   (peak_total),
        .last_of_run  (last_of_run)
    );

endmodule

`default_nettype wire

// ===== tb/tb_local_max_peak_finder_3x3_unit.sv =====
// Self-checking testbench for local_max_peak_finder_3x3_unit.
// Drives pixel frames and register settings and compares every result beat against
// an in-bench window model. Depends on lmpf_pkg and the unit's RTL.
`default_nettype none

module tb_local_max_peak_finder_3x3_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import lmpf_pkg::*;

    localparam int LINE_DEPTH  = 4096;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RANDOM_ITEMS = 750;

    typedef struct {
        logic        kind;
        logic [19:0] col;
        logic [23:0] row;
        logic [23:0] total;
        logic        last;
    } record_t;

    typedef struct {
        logic [15:0] pix;
        bit          typed;
        logic [19:0] col;
        logic [23:0] row;
        logic [23:0] total;
    } pixel_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic pixel_valid = 1'b0;
    logic pixel_ready;
    logic [15:0] pixel_value = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    logic record_kind;
    logic [COLUMN_Q_BITS-1:0] column_q8;
    logic [ROW_Q_BITS-1:0] row_q8;
    logic [COUNT_BITS-1:0] peak_total;
    logic last_of_run;

    // Predictor copy of the registers and the block's state.
    logic [12:0] m_width;
    logic [15:0] m_height, m_thresh, m_margin;
    logic        m_subpix;
    logic [15:0] older_line[LINE_DEPTH];
    logic [15:0] newer_line[LINE_DEPTH];
    logic [15:0] window[9];
    logic [11:0] col_pos;
    logic [15:0] row_pos;
    logic [23:0] peaks_in_frame;

    record_t pending_records[$];
    int errors = 0;
    int pixels_sent = 0;
    int cycles = 0;
    int idle_mode = 0;   // 0: receiver idles more, 1: sender idles more, 2: no idling
    bit hold_request = 0;
    int hold_cycles = 0;

    pixel_row_t directed[18];

    local_max_peak_finder_3x3_unit uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pixel_valid(pixel_valid), .pixel_ready(pixel_ready), .pixel_value(pixel_value),
        .result_valid(result_valid), .result_ready(result_ready),
        .record_kind(record_kind), .column_q8(column_q8), .row_q8(row_q8),
        .peak_total(peak_total), .last_of_run(last_of_run)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off, and the check of each beat.
    always @(posedge clk)
    begin
        record_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (pending_records.size() == 0)
                begin
                    $error("unexpected result beat: kind %0d", record_kind);
                    errors++;
                end
                else
                begin
                    want = pending_records.pop_front();
                    if (record_kind !== want.kind)
                    begin
                        $error("record_kind exp %0d got %0d", want.kind, record_kind);
                        errors++;
                    end
                    if (column_q8 !== want.col)
                    begin
                        $error("column_q8 exp %0d got %0d", want.col, column_q8);
                        errors++;
                    end
                    if (row_q8 !== want.row)
                    begin
                        $error("row_q8 exp %0d got %0d", want.row, row_q8);
                        errors++;
                    end
                    if (peak_total !== want.total)
                    begin
                        $error("peak_total exp %0d got %0d", want.total, peak_total);
                        errors++;
                    end
                    if (last_of_run !== want.last)
                    begin
                        $error("last_of_run exp %0d got %0d", want.last, last_of_run);
                        errors++;
                    end
                end
            end
            if (hold_request && hold_cycles == 0)
            begin
                hold_request = 0;
                hold_cycles = 400;
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                result_ready <= 1'b0;
            end
            else if (idle_mode == 0)
                result_ready <= ($urandom_range(99) >= 61);
            else if (idle_mode == 1)
                result_ready <= ($urandom_range(99) >= 38);
            else
                result_ready <= 1'b1;
        end
    end

    function automatic logic [15:0] effective_width();
        if (m_width < 3)
            return 3;
        if (m_width > LINE_DEPTH)
            return LINE_DEPTH;
        return m_width;
    endfunction

    // Advances the model by one pixel and queues the records it causes.
    task automatic classify_pixel(input logic [15:0] p, output int n, output record_t first);
        logic [15:0] w, h, c, r, ctr;
        longint sum, dx, dy, colq, rowq;
        bit peak;
        record_t rec;
        w = effective_width();
        h = (m_height < 3) ? 16'd3 : m_height;
        c = col_pos;
        r = row_pos;
        n = 0;
        for (int i = 0; i < 3; i++)
        begin
            window[i*3] = window[i*3+1];
            window[i*3+1] = window[i*3+2];
        end
        window[2] = older_line[c];
        window[5] = newer_line[c];
        window[8] = p;
        older_line[c] = newer_line[c];
        newer_line[c] = p;
        if (r >= 2 && c >= 2 && c <= w - 1 && r <= h - 1)
        begin
            ctr = window[4];
            peak = (ctr > m_thresh);
            for (int k = 0; k < 9; k++)
                if (k != 4 && !({16'd0, window[k]} + m_margin < {16'd0, ctr}))
                    peak = 0;
            if (peak)
            begin
                colq = longint'(c - 1) * 256;
                rowq = longint'(r - 1) * 256;
                if (m_subpix)
                begin
                    sum = 0;
                    for (int k = 0; k < 9; k++)
                        sum += window[k];
                    dx = longint'(window[2]) + window[5] + window[8]
                       - window[0] - window[3] - window[6];
                    dy = longint'(window[6]) + window[7] + window[8]
                       - window[0] - window[1] - window[2];
                    if (sum > 0)
                    begin
                        colq += dx * 256 / sum;
                        rowq += dy * 256 / sum;
                    end
                end
                if (colq < 0)
                    colq = 0;
                if (rowq < 0)
                    rowq = 0;
                if (peaks_in_frame != COUNT_MAX)
                    peaks_in_frame++;
                rec = '{KIND_PEAK, colq[19:0], rowq[23:0], peaks_in_frame, 1'b0};
                first = rec;
                pending_records.push_back(rec);
                n++;
            end
        end
        if (c >= w - 1)
        begin
            col_pos = 0;
            if (r >= h - 1)
            begin
                rec = '{KIND_SUMMARY, 20'd0, 24'd0, peaks_in_frame, 1'b0};
                if (n == 0)
                    first = rec;
                pending_records.push_back(rec);
                n++;
                row_pos = 0;
                peaks_in_frame = 0;
            end
            else
                row_pos = r + 1;
        end
        else
            col_pos = c + 1;
        if (n > 0)
            pending_records[$].last = 1'b1;
    endtask

    // Offers one pixel beat and returns right after the edge that takes it.
    task automatic send_pixel(input logic [15:0] p, output int n, output record_t first);
        int gaps, pct;
        gaps = 0;
        pct = (idle_mode == 0) ? 38 : (idle_mode == 1) ? 61 : 0;
        while (gaps < 30 && $urandom_range(99) < pct)
            gaps++;
        if (gaps > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gaps) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_value <= p;
        do
            @(posedge clk);
        while (!pixel_ready);
        classify_pixel(p, n, first);
        pixels_sent++;
        if (pixels_sent == 300)
            hold_request = 1;
        if (pixels_sent < RANDOM_ITEMS / 3)
            idle_mode = 0;
        else if (pixels_sent < 2 * RANDOM_ITEMS / 3)
            idle_mode = 1;
        else
            idle_mode = 2;
    endtask

    task automatic wait_idle();
        pixel_valid <= 1'b0;
        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_FRAME_WIDTH:      m_width = val[12:0];
            REG_FRAME_HEIGHT:     m_height = val;
            REG_PEAK_THRESHOLD:   m_thresh = val;
            REG_STABILITY_MARGIN: m_margin = val;
            default:              m_subpix = val[0];
        endcase
    endtask

    task automatic configure(input logic [15:0] w, input logic [15:0] h, input logic [15:0] t,
                             input logic [15:0] m, input logic s);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_PEAK_THRESHOLD, t);
        write_reg(REG_STABILITY_MARGIN, m);
        write_reg(REG_SUBPIXEL_ENABLE, {15'd0, s});
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Sends whole frames; style 0 is noise, 1 is a narrow range full of ties,
    // 2 is isolated bright spots over a dim background.
    task automatic send_frames(input int frames, input int style);
        int n, total;
        record_t first;
        logic [15:0] p;
        total = frames * effective_width() * ((m_height < 3) ? 3 : m_height);
        for (int i = 0; i < total; i++)
        begin
            if (style == 0)
                p = $urandom;
            else if (style == 1)
                p = $urandom_range(3);
            else
                p = ($urandom_range(9) == 0) ? 16'($urandom_range(65535, 200))
                                            : 16'($urandom_range(150));
            send_pixel(p, n, first);
        end
    endtask

    initial
    begin
        int n;
        record_t first;
        logic [15:0] w;
        m_width = WIDTH_RESET;
        m_height = HEIGHT_RESET;
        m_thresh = 0;
        m_margin = 0;
        m_subpix = 0;
        foreach (window[k])
            window[k] = 0;
        col_pos = 0;
        row_pos = 0;
        peaks_in_frame = 0;

        // Two 3x3 frames: a full-scale centre over zeros, then a centre of one
        // ringed by full-scale border pixels, which gives no peak.
        directed = '{
            '{16'h0000, 0, 0, 0, 0}, '{16'h0000, 0, 0, 0, 0}, '{16'h0000, 0, 0, 0, 0},
            '{16'h0000, 0, 0, 0, 0}, '{16'hFFFF, 0, 0, 0, 0}, '{16'h0000, 0, 0, 0, 0},
            '{16'h0000, 0, 0, 0, 0}, '{16'h0000, 0, 0, 0, 0}, '{16'h0000, 1, 256, 256, 1},
            '{16'hFFFF, 0, 0, 0, 0}, '{16'hFFFF, 0, 0, 0, 0}, '{16'hFFFF, 0, 0, 0, 0},
            '{16'hFFFF, 0, 0, 0, 0}, '{16'h0001, 0, 0, 0, 0}, '{16'hFFFF, 0, 0, 0, 0},
            '{16'hFFFF, 0, 0, 0, 0}, '{16'hFFFF, 0, 0, 0, 0}, '{16'hFFFF, 0, 0, 0, 0}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Width below range acts as three, height zero acts as three.
        configure(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        foreach (directed[i])
        begin
            send_pixel(directed[i].pix, n, first);
            if (directed[i].typed &&
                (first.kind !== KIND_PEAK || first.col !== directed[i].col ||
                 first.row !== directed[i].row || first.total !== directed[i].total))
            begin
                $error("directed row %0d: predictor disagrees with the typed result", i);
                errors++;
            end
        end
        wait_idle();

        // Centroid on, widest margin: no centre can clear it.
        configure(16'd3, 16'd3, 16'd0, 16'hFFFF, 1'b1);
        send_frames(1, 0);
        wait_idle();
        // Highest threshold blocks every peak.
        configure(16'd4, 16'd3, 16'hFFFF, 16'd0, 1'b1);
        send_frames(1, 2);
        wait_idle();

        while (pixels_sent < RANDOM_ITEMS)
        begin
            w = $urandom_range(12, 3);
            configure(w, 16'($urandom_range(7, 3)),
                      ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1)),
                      ($urandom_range(3) == 0) ? 16'($urandom_range(40)) : 16'd0,
                      1'($urandom_range(1)));
            send_frames($urandom_range(2, 1), $urandom_range(2));
            wait_idle();
        end

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== local_max_peak_finder_3x3_unit.f =====
hdl/lmpf_pkg.sv
hdl/lmpf_ram.sv
hdl/lmpf_fifo.sv
hdl/lmpf_front.sv
hdl/lmpf_back.sv
hdl/local_max_peak_finder_3x3_unit.sv
tb/tb_local_max_peak_finder_3x3_unit.sv
